@@ hdl/dlsc_pkg.sv @@
// Package for the loss-scale controller: widths, reset values, register indexes, codes.
`default_nettype none
package dlsc_pkg;

    localparam int DEF_COUNTER_WIDTH = 32;
    localparam int DEF_FRAC_BITS     = 16;

    localparam int SCALE_W   = 33;
    localparam int FACTOR_W  = 20;
    localparam int TEMP_W    = 13;
    localparam int CFG_W     = 32;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [SCALE_W-1:0]  INIT_SCALE_RST      = 33'h1_0000_0000;
    localparam logic [FACTOR_W-1:0] GROWTH_FACTOR_RST   = 20'd131072;
    localparam logic [FACTOR_W-1:0] BACKOFF_FACTOR_RST  = 20'd32768;
    localparam logic [CFG_W-1:0]    GROW_PERIOD_RST     = 32'd2000;
    localparam logic [CFG_W-1:0]    OVERFLOW_LIMIT_RST  = 32'd5;
    localparam logic [TEMP_W-1:0]   THROTTLE_TEMP_RST   = 13'd1328;

    localparam logic [SCALE_W-1:0]  SCALE_MAX = {SCALE_W{1'b1}};

    // register indexes, taken from paddr[5:3]
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_SCALE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GROWTH_FACTOR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BACKOFF_FACTOR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GROW_PERIOD     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OVERFLOW_LIMIT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THROTTLE_TEMP   = 3'd5;

    localparam logic CMD_STEP     = 1'b0;
    localparam logic CMD_REENABLE = 1'b1;

endpackage
`default_nettype wire

@@ hdl/dlsc_if.sv @@
// Valid/ready channel interfaces for step words and result words.
`default_nettype none
interface dlsc_step_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic                               overflow_seen;
    logic signed [dlsc_pkg::TEMP_W-1:0] temperature;

    modport source (output valid, cmd, overflow_seen, temperature, input ready);
    modport sink   (input valid, cmd, overflow_seen, temperature, output ready);
endinterface

interface dlsc_result_if #(
    parameter int COUNTER_WIDTH = dlsc_pkg::DEF_COUNTER_WIDTH
);
    logic                                valid;
    logic                                ready;
    logic [dlsc_pkg::SCALE_W-1:0]        loss_scale;
    logic                                fp16_enabled;
    logic                                throttled;
    logic [COUNTER_WIDTH-1:0]            overflow_run;
    logic [COUNTER_WIDTH-1:0]            clean_steps;
    logic [COUNTER_WIDTH-1:0]            overflow_total;
    logic [COUNTER_WIDTH-1:0]            grow_total;
    logic [COUNTER_WIDTH-1:0]            shrink_total;
    logic signed [dlsc_pkg::TEMP_W-1:0]  last_temperature;

    modport source (output valid, loss_scale, fp16_enabled, throttled, overflow_run,
                    clean_steps, overflow_total, grow_total, shrink_total,
                    last_temperature, input ready);
    modport sink   (input valid, loss_scale, fp16_enabled, throttled, overflow_run,
                    clean_steps, overflow_total, grow_total, shrink_total,
                    last_temperature, output ready);
endinterface
`default_nettype wire

@@ hdl/dynamic_loss_scale_controller_top.sv @@
// Dynamic loss-scale controller: APB register file, step pipeline and scale update.
// Takes one word per training step (or a reenable command) and returns one result word for
// each. Throughput is one word per cycle; a word lands in the input register when taken, and
// once the result register is free the update logic (one 33x20 scale-times-factor multiply,
// its clamps and the counter compares) writes the controller state, which doubles as the
// result register from which the result word is offered. The input stalls only while the
// input register is full and the result word ahead of it is not taken.
// A step that overflows multiplies the Q17.16 scale by the backoff factor with a floor of 1.0
// and counts toward the overflow run; a run at or past overflow_limit drops to FP32. A clean
// step counts toward the growth period and, once reached, multiplies by the growth factor with
// a ceiling of 65536.0. A reenable word restores FP16, reloads initial_scale and clears the
// run. Registers sit at byte address 8*i on a 64-bit APB port; write only while idle.
`default_nettype none
module dynamic_loss_scale_controller_top #(
    parameter int COUNTER_WIDTH = dlsc_pkg::DEF_COUNTER_WIDTH,
    parameter int FRAC_BITS     = dlsc_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dlsc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dlsc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dlsc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    dlsc_step_if.sink                          step_ch,
    dlsc_result_if.source                      result_ch
);
    import dlsc_pkg::*;

    localparam int PROD_W = SCALE_W + FACTOR_W;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << FRAC_BITS;
    // ceiling may lie beyond the 33-bit scale for large FRAC_BITS; compare it wide
    localparam logic [63:0]        SCALE_CEIL = 64'd65536 << FRAC_BITS;

    // ---------------------------------------------------------------- registers
    logic [SCALE_W-1:0]       initial_scale_reg;
    logic [FACTOR_W-1:0]      growth_factor_reg;
    logic [FACTOR_W-1:0]      backoff_factor_reg;
    logic [CFG_W-1:0]         grow_period_reg;
    logic [CFG_W-1:0]         overflow_limit_reg;
    logic signed [TEMP_W-1:0] throttle_temp_reg;

    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_scale_reg   <= INIT_SCALE_RST;
            growth_factor_reg   <= GROWTH_FACTOR_RST;
            backoff_factor_reg  <= BACKOFF_FACTOR_RST;
            grow_period_reg     <= GROW_PERIOD_RST;
            overflow_limit_reg  <= OVERFLOW_LIMIT_RST;
            throttle_temp_reg   <= THROTTLE_TEMP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_INITIAL_SCALE:   initial_scale_reg   <= pwdata[SCALE_W-1:0];
                REG_GROWTH_FACTOR:   growth_factor_reg   <= pwdata[FACTOR_W-1:0];
                REG_BACKOFF_FACTOR:  backoff_factor_reg  <= pwdata[FACTOR_W-1:0];
                REG_GROW_PERIOD:     grow_period_reg     <= pwdata[CFG_W-1:0];
                REG_OVERFLOW_LIMIT:  overflow_limit_reg  <= pwdata[CFG_W-1:0];
                REG_THROTTLE_TEMP:   throttle_temp_reg   <= pwdata[TEMP_W-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_INITIAL_SCALE:   prdata = PDATA_W'(initial_scale_reg);
            REG_GROWTH_FACTOR:   prdata = PDATA_W'(growth_factor_reg);
            REG_BACKOFF_FACTOR:  prdata = PDATA_W'(backoff_factor_reg);
            REG_GROW_PERIOD:     prdata = PDATA_W'(grow_period_reg);
            REG_OVERFLOW_LIMIT:  prdata = PDATA_W'(overflow_limit_reg);
            REG_THROTTLE_TEMP:   prdata = PDATA_W'(unsigned'(throttle_temp_reg));
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    // The controller state is the result register: it changes only when the
    // previous result is gone or leaving this cycle.
    logic                     in_vld_reg;
    logic                     cmd_reg;
    logic                     ovf_reg;
    logic signed [TEMP_W-1:0] temp_in_reg;
    logic                     out_vld_reg;

    logic step_take;
    logic result_take;
    logic slot_free;
    logic fire;

    assign result_take   = out_vld_reg && result_ch.ready;
    assign slot_free     = !out_vld_reg || result_ch.ready;
    assign fire          = in_vld_reg && slot_free;
    assign step_ch.ready = !in_vld_reg || fire;
    assign step_take     = step_ch.valid && step_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (step_take)
                in_vld_reg <= 1'b1;
            else if (fire)
                in_vld_reg <= 1'b0;

            if (fire)
                out_vld_reg <= 1'b1;
            else if (result_take)
                out_vld_reg <= 1'b0;
        end
    end

    // hold the step word until the update consumes it
    always_ff @(posedge clk)
    begin
        if (step_take)
        begin
            cmd_reg     <= step_ch.cmd;
            ovf_reg     <= step_ch.overflow_seen;
            temp_in_reg <= step_ch.temperature;
        end
    end

    // ---------------------------------------------------------------- state
    logic [SCALE_W-1:0]       scale_reg,         scale_next;
    logic                     fp16_reg,          fp16_next;
    logic [COUNTER_WIDTH-1:0] since_growth_reg,  since_growth_next;
    logic [COUNTER_WIDTH-1:0] streak_reg,        streak_next;
    logic [COUNTER_WIDTH-1:0] ovf_count_reg,     ovf_count_next;
    logic [COUNTER_WIDTH-1:0] grow_count_reg,    grow_count_next;
    logic [COUNTER_WIDTH-1:0] shrink_count_reg,  shrink_count_next;
    logic                     throttle_reg,      throttle_next;
    logic signed [TEMP_W-1:0] temp_reg,          temp_next;

    // one shared multiplier: backoff on overflow, growth otherwise
    logic [FACTOR_W-1:0]      factor;
    logic [PROD_W-1:0]        product;
    logic [PROD_W-1:0]        prod_shift;
    logic [SCALE_W-1:0]       scale_mul;
    logic [COUNTER_WIDTH-1:0] streak_inc;
    logic [COUNTER_WIDTH-1:0] since_inc;
    logic [CFG_W-1:0]         streak_ext;
    logic [CFG_W-1:0]         since_ext;

    assign factor     = ovf_reg ? backoff_factor_reg : growth_factor_reg;
    assign product    = PROD_W'(scale_reg) * PROD_W'(factor);
    assign prod_shift = product >> FRAC_BITS;
    assign scale_mul  = (prod_shift > PROD_W'(SCALE_MAX)) ? SCALE_MAX
                                                          : prod_shift[SCALE_W-1:0];
    assign streak_inc = streak_reg + 1'b1;
    assign since_inc  = since_growth_reg + 1'b1;
    assign streak_ext = CFG_W'(streak_inc);
    assign since_ext  = CFG_W'(since_inc);

    always_comb
    begin
        scale_next        = scale_reg;
        fp16_next         = fp16_reg;
        since_growth_next = since_growth_reg;
        streak_next       = streak_reg;
        ovf_count_next    = ovf_count_reg;
        grow_count_next   = grow_count_reg;
        shrink_count_next = shrink_count_reg;
        throttle_next     = throttle_reg;
        temp_next         = temp_reg;

        if (cmd_reg == CMD_REENABLE)
        begin
            fp16_next   = 1'b1;
            streak_next = '0;
            scale_next  = initial_scale_reg;
        end
        else
        begin
            temp_next     = temp_in_reg;
            throttle_next = (temp_in_reg >= throttle_temp_reg);
            if (ovf_reg)
            begin
                streak_next       = streak_inc;
                ovf_count_next    = ovf_count_reg + 1'b1;
                shrink_count_next = shrink_count_reg + 1'b1;
                since_growth_next = '0;
                // floor at 1.0
                scale_next        = (scale_mul < SCALE_ONE) ? SCALE_ONE : scale_mul;
                if (streak_ext >= overflow_limit_reg)
                    fp16_next = 1'b0;
            end
            else
            begin
                streak_next       = '0;
                since_growth_next = since_inc;
                if (since_ext >= grow_period_reg)
                begin
                    // ceiling at 65536.0, no floor on growth
                    scale_next        = (64'(scale_mul) > SCALE_CEIL) ? SCALE_CEIL[SCALE_W-1:0]
                                                                      : scale_mul;
                    grow_count_next   = grow_count_reg + 1'b1;
                    since_growth_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg        <= INIT_SCALE_RST;
            fp16_reg         <= 1'b1;
            since_growth_reg <= '0;
            streak_reg       <= '0;
            ovf_count_reg    <= '0;
            grow_count_reg   <= '0;
            shrink_count_reg <= '0;
            throttle_reg     <= 1'b0;
            temp_reg         <= '0;
        end
        else if (fire)
        begin
            scale_reg        <= scale_next;
            fp16_reg         <= fp16_next;
            since_growth_reg <= since_growth_next;
            streak_reg       <= streak_next;
            ovf_count_reg    <= ovf_count_next;
            grow_count_reg   <= grow_count_next;
            shrink_count_reg <= shrink_count_next;
            throttle_reg     <= throttle_next;
            temp_reg         <= temp_next;
        end
    end

    // ---------------------------------------------------------------- result word
    assign result_ch.valid            = out_vld_reg;
    assign result_ch.loss_scale       = scale_reg;
    assign result_ch.fp16_enabled     = fp16_reg;
    assign result_ch.throttled        = throttle_reg;
    assign result_ch.overflow_run     = streak_reg;
    assign result_ch.clean_steps      = since_growth_reg;
    assign result_ch.overflow_total   = ovf_count_reg;
    assign result_ch.grow_total       = grow_count_reg;
    assign result_ch.shrink_total     = shrink_count_reg;
    assign result_ch.last_temperature = temp_reg;

    // ---------------------------------------------------------------- checks
    // an overflow step never leaves the scale below 1.0 and clears the clean-step count
    a_backoff_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_STEP && ovf_reg)
        |=> (scale_reg >= SCALE_ONE && since_growth_reg == '0))
        else $error("backoff left scale below floor or clean count set");

    // reenable restores FP16 and clears the run
    a_reenable: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_REENABLE) |=> (fp16_reg && streak_reg == '0))
        else $error("reenable did not restore FP16");

    // a clean step breaks the overflow run
    a_clean_run: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_STEP && !ovf_reg) |=> (streak_reg == '0))
        else $error("clean step kept the overflow run");

    // state moves only with a word leaving the input register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(scale_reg) && $stable(ovf_count_reg))
        else $error("state changed without a step word");

endmodule
`default_nettype wire

@@ tb/tb_dynamic_loss_scale_controller_top.sv @@
// Testbench for the loss-scale controller: directed table, random phases, scoreboard check.
`timescale 1ns / 100ps
module tb_dynamic_loss_scale_controller_top;
    import dlsc_pkg::*;

    localparam int CNT_W        = DEF_COUNTER_WIDTH;
    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 85;
    localparam int HOLD_CYCLES  = 120;
    localparam int SETTLE       = 6;       // input and result registers plus margin
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [SCALE_W-1:0] SCALE_ONE  = 33'd1 << FRAC;
    localparam logic [SCALE_W-1:0] SCALE_CEIL = 33'd65536 << FRAC;

    typedef struct packed {
        logic [SCALE_W-1:0]       loss_scale;
        logic                     fp16_enabled;
        logic                     throttled;
        logic [CNT_W-1:0]         overflow_run;
        logic [CNT_W-1:0]         clean_steps;
        logic [CNT_W-1:0]         overflow_total;
        logic [CNT_W-1:0]         grow_total;
        logic [CNT_W-1:0]         shrink_total;
        logic signed [TEMP_W-1:0] last_temperature;
    } scale_result_t;

    // A pinned word carries a result typed in by hand instead of the predicted one.
    typedef struct {
        bit            pinned;
        scale_result_t want;
    } pin_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic                     cmd;
        logic                     ovf;
        logic signed [TEMP_W-1:0] temp;
        pin_t                     pin;
        logic [REG_IDX_W-1:0]     idx;
        logic [PDATA_W-1:0]       value;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 psel, penable, pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    dlsc_step_if                           step_ch();
    dlsc_result_if #(.COUNTER_WIDTH(CNT_W)) result_ch();

    dynamic_loss_scale_controller_top #(
        .COUNTER_WIDTH(CNT_W),
        .FRAC_BITS    (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .step_ch  (step_ch),
        .result_ch(result_ch)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the register file, updated as each APB write lands.
    logic [SCALE_W-1:0]       cfg_initial_scale;
    logic [FACTOR_W-1:0]      cfg_growth_factor;
    logic [FACTOR_W-1:0]      cfg_backoff_factor;
    logic [CFG_W-1:0]         cfg_grow_period;
    logic [CFG_W-1:0]         cfg_overflow_limit;
    logic signed [TEMP_W-1:0] cfg_throttle_temp;

    // Predicted controller state.
    logic [SCALE_W-1:0]       cur_scale;
    logic                     fp16_mode;
    logic [CNT_W-1:0]         clean_run;
    logic [CNT_W-1:0]         ovf_streak;
    logic [CNT_W-1:0]         ovf_seen_total;
    logic [CNT_W-1:0]         grow_seen_total;
    logic [CNT_W-1:0]         shrink_seen_total;
    logic                     throttle_now;
    logic signed [TEMP_W-1:0] temp_seen;

    scale_result_t expected_scale_q[$];
    pin_t          pin_q[$];
    stim_row_t     directed_rows[$];

    int error_count  = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit valid_up     = 1'b0;
    bit no_idle      = 1'b0;
    bit hold_pending = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q17.16 scale times Q4.16 factor, truncated, saturated at the register maximum.
    function automatic logic [SCALE_W-1:0] scaled_by(input logic [SCALE_W-1:0] s,
                                                     input logic [FACTOR_W-1:0] f);
        logic [SCALE_W+FACTOR_W-1:0] prod;
        prod = s * f;
        prod = prod >> FRAC;
        if (prod > SCALE_MAX)
            return SCALE_MAX;
        return prod[SCALE_W-1:0];
    endfunction

    function automatic void reset_controller_model();
        cfg_initial_scale   = INIT_SCALE_RST;
        cfg_growth_factor   = GROWTH_FACTOR_RST;
        cfg_backoff_factor  = BACKOFF_FACTOR_RST;
        cfg_grow_period     = GROW_PERIOD_RST;
        cfg_overflow_limit  = OVERFLOW_LIMIT_RST;
        cfg_throttle_temp   = THROTTLE_TEMP_RST;
        cur_scale           = INIT_SCALE_RST;
        fp16_mode           = 1'b1;
        clean_run           = '0;
        ovf_streak          = '0;
        ovf_seen_total      = '0;
        grow_seen_total     = '0;
        shrink_seen_total   = '0;
        throttle_now        = 1'b0;
        temp_seen           = '0;
    endfunction

    // Advance the predicted state by one word and return the result it must produce.
    function automatic scale_result_t step_controller(input logic c, input logic o,
                                                      input logic signed [TEMP_W-1:0] t);
        scale_result_t r;
        if (c == CMD_REENABLE)
        begin
            fp16_mode  = 1'b1;
            ovf_streak = '0;
            cur_scale  = cfg_initial_scale;
        end
        else
        begin
            temp_seen    = t;
            throttle_now = (t >= cfg_throttle_temp);
            if (o)
            begin
                ovf_streak        = ovf_streak + 1'b1;
                ovf_seen_total    = ovf_seen_total + 1'b1;
                cur_scale         = scaled_by(cur_scale, cfg_backoff_factor);
                if (cur_scale < SCALE_ONE)
                    cur_scale = SCALE_ONE;
                shrink_seen_total = shrink_seen_total + 1'b1;
                clean_run         = '0;
                if (ovf_streak >= cfg_overflow_limit)
                    fp16_mode = 1'b0;
            end
            else
            begin
                ovf_streak = '0;
                clean_run  = clean_run + 1'b1;
                if (clean_run >= cfg_grow_period)
                begin
                    cur_scale = scaled_by(cur_scale, cfg_growth_factor);
                    if (cur_scale > SCALE_CEIL)
                        cur_scale = SCALE_CEIL;
                    grow_seen_total = grow_seen_total + 1'b1;
                    clean_run       = '0;
                end
            end
        end
        r.loss_scale       = cur_scale;
        r.fp16_enabled     = fp16_mode;
        r.throttled        = throttle_now;
        r.overflow_run     = ovf_streak;
        r.clean_steps      = clean_run;
        r.overflow_total   = ovf_seen_total;
        r.grow_total       = grow_seen_total;
        r.shrink_total     = shrink_seen_total;
        r.last_temperature = temp_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic void add_word(input logic c, input logic o,
                                     input logic signed [TEMP_W-1:0] t);
        stim_row_t row;
        row.kind       = ROW_WORD;
        row.cmd        = c;
        row.ovf        = o;
        row.temp       = t;
        row.pin.pinned = 1'b0;
        row.pin.want   = '0;
        row.idx        = '0;
        row.value      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pinned(input logic o, input logic signed [TEMP_W-1:0] t,
                                       input logic [SCALE_W-1:0] scale,
                                       input logic thr, input logic [CNT_W-1:0] run,
                                       input logic [CNT_W-1:0] clean,
                                       input logic [CNT_W-1:0] ovt,
                                       input logic [CNT_W-1:0] shrink);
        stim_row_t row;
        row.kind       = ROW_WORD;
        row.cmd        = CMD_STEP;
        row.ovf        = o;
        row.temp       = t;
        row.pin.pinned = 1'b1;
        row.pin.want   = '{loss_scale: scale, fp16_enabled: 1'b1, throttled: thr,
                           overflow_run: run, clean_steps: clean, overflow_total: ovt,
                           grow_total: '0, shrink_total: shrink, last_temperature: t};
        row.idx        = '0;
        row.value      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [PDATA_W-1:0] value);
        stim_row_t row;
        row.kind       = ROW_REG;
        row.cmd        = CMD_STEP;
        row.ovf        = 1'b0;
        row.temp       = '0;
        row.pin.pinned = 1'b0;
        row.pin.want   = '0;
        row.idx        = idx;
        row.value      = value;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // APB write: setup, access, then idle with psel low so the next
    // setup never lands in the step that drops psel.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INITIAL_SCALE:   cfg_initial_scale   = value[SCALE_W-1:0];
            REG_GROWTH_FACTOR:   cfg_growth_factor   = value[FACTOR_W-1:0];
            REG_BACKOFF_FACTOR:  cfg_backoff_factor  = value[FACTOR_W-1:0];
            REG_GROW_PERIOD:     cfg_grow_period     = value[CFG_W-1:0];
            REG_OVERFLOW_LIMIT:  cfg_overflow_limit  = value[CFG_W-1:0];
            REG_THROTTLE_TEMP:   cfg_throttle_temp   = value[TEMP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one step word and hold it until accepted. Bursts of random length
    // are separated by random gaps unless the phase runs with no idling.
    task automatic drive_word(input logic c, input logic o,
                              input logic signed [TEMP_W-1:0] t, input pin_t pin);
        int gap;
        pin_q.push_back(pin);
        step_ch.valid         <= 1'b1;
        step_ch.cmd           <= c;
        step_ch.overflow_seen <= o;
        step_ch.temperature   <= t;
        valid_up = 1'b1;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!no_idle)
            begin
                gap = $urandom_range(1, 5);
                step_ch.valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait for every outstanding result, then let the pipe settle.
    task automatic drain_results();
        if (valid_up)
        begin
            step_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (expected_scale_q.size() != 0 || pin_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Program all six registers for a random phase; phase 0 forces the
    // wide extremes of the growth factor, period and limit registers.
    task automatic program_registers(input int phase);
        logic [PDATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'd65536;
            1: v = 64'h1_0000_0000;
            2: v = {31'd0, SCALE_MAX};
            3: v = 64'd0;
            default: v = {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
        endcase
        write_reg(REG_INITIAL_SCALE, v);

        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = 64'hF_FFFF;
            2: v = 64'd131072;
            3: v = 64'd65536 + 64'($urandom_range(0, 4096)) - 64'd2048;
            default: v = 64'(20'($urandom));
        endcase
        if (phase == 0)
            v = 64'hF_FFFF;
        write_reg(REG_GROWTH_FACTOR, v);

        case ($urandom_range(0, 4))
            0: v = 64'd0;
            1: v = 64'hF_FFFF;
            2: v = 64'd32768;
            default: v = 64'(20'($urandom));
        endcase
        write_reg(REG_BACKOFF_FACTOR, v);

        case ($urandom_range(0, 7))
            0: v = 64'hFFFF_FFFF;
            1: v = 64'd2000;
            2: v = 64'(32'($urandom));
            default: v = 64'($urandom_range(0, 10));
        endcase
        if (phase == 0)
            v = 64'hFFFF_FFFF;
        write_reg(REG_GROW_PERIOD, v);

        case ($urandom_range(0, 6))
            0: v = 64'hFFFF_FFFF;
            1: v = 64'(32'($urandom));
            default: v = 64'($urandom_range(0, 8));
        endcase
        if (phase == 0)
            v = 64'hFFFF_FFFF;
        write_reg(REG_OVERFLOW_LIMIT, v);

        case ($urandom_range(0, 4))
            0: v = 64'h1000;
            1: v = 64'h0FFF;
            2: v = 64'd1328;
            default: v = 64'(13'($urandom));
        endcase
        write_reg(REG_THROTTLE_TEMP, v);
    endtask

    // Full-range temperatures, with a share at the extremes and around the threshold.
    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        logic [TEMP_W-1:0] d;
        case ($urandom_range(0, 3))
            0:
            begin
                d = 13'($urandom_range(0, 2));
                return cfg_throttle_temp + d - 1'b1;
            end
            1: return $urandom_range(0, 1) ? 13'sh0FFF : 13'sh1000;
            default: return 13'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input acceptance, compare on output acceptance
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        scale_result_t pred;
        scale_result_t want;
        pin_t          pin;
        if (rst_n)
        begin
            // Each accepted step word advances the predictor; a pinned row
            // replaces the predicted value with the hand-typed one.
            if (step_ch.valid && step_ch.ready)
            begin
                pred = step_controller(step_ch.cmd, step_ch.overflow_seen,
                                       step_ch.temperature);
                if (pin_q.size() != 0)
                begin
                    pin = pin_q.pop_front();
                    if (pin.pinned)
                        pred = pin.want;
                end
                expected_scale_q.push_back(pred);
            end
            // Compare every accepted result word with the oldest expectation.
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_scale_q.size() == 0)
                begin
                    $error("result word arrived with no expectation pending");
                    error_count++;
                end
                else
                begin
                    want = expected_scale_q.pop_front();
                    check_field("loss_scale", want.loss_scale, result_ch.loss_scale);
                    check_field("fp16_enabled", want.fp16_enabled, result_ch.fp16_enabled);
                    check_field("throttled", want.throttled, result_ch.throttled);
                    check_field("overflow_run", want.overflow_run, result_ch.overflow_run);
                    check_field("clean_steps", want.clean_steps, result_ch.clean_steps);
                    check_field("overflow_total", want.overflow_total,
                                result_ch.overflow_total);
                    check_field("grow_total", want.grow_total, result_ch.grow_total);
                    check_field("shrink_total", want.shrink_total, result_ch.shrink_total);
                    check_field("last_temperature", want.last_temperature,
                                result_ch.last_temperature);
                end
            end
        end
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: its own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int tick;
        mode = 0;
        tick = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                // Hold off long enough for the pipe to fill and back up the input.
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else
            begin
                tick++;
                if (tick % 48 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ($urandom_range(0, 2) == 0);
                    default: result_ch.ready <= (tick % 5 >= 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        pin_t      no_pin;
        int        ovf_pct;
        logic      c;
        logic      o;

        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        step_ch.valid         <= 1'b0;
        step_ch.cmd           <= CMD_STEP;
        step_ch.overflow_seen <= 1'b0;
        step_ch.temperature   <= '0;
        no_pin.pinned = 1'b0;
        no_pin.want   = '0;
        reset_controller_model();

        // Reset values: first steps are typed in by hand (scale 65536.0,
        // backoff 0.5, threshold 83.0 C), including the field extremes and
        // a temperature exactly at the threshold.
        add_pinned(1'b0, 13'sd0, 33'h1_0000_0000, 1'b0, 0, 1, 0, 0);
        add_pinned(1'b1, 13'sh0FFF, 33'h0_8000_0000, 1'b1, 1, 0, 1, 1);
        add_pinned(1'b0, 13'sh1000, 33'h0_8000_0000, 1'b0, 0, 1, 1, 1);
        add_pinned(1'b0, 13'sd1328, 33'h0_8000_0000, 1'b1, 0, 2, 1, 1);
        add_word(CMD_STEP, 1'b0, 13'sd1327);
        // Run of overflows reaching the limit, then one more while in FP32.
        add_word(CMD_STEP, 1'b1, 13'sd100);
        add_word(CMD_STEP, 1'b1, 13'sd2000);
        add_word(CMD_STEP, 1'b1, -13'sd5);
        add_word(CMD_STEP, 1'b1, 13'sd1500);
        add_word(CMD_STEP, 1'b1, 13'sd0);
        add_word(CMD_STEP, 1'b1, 13'sd1);
        add_word(CMD_REENABLE, 1'b1, 13'sh0FFF);
        // Zero growth period: every clean step grows, clamped at the ceiling.
        add_reg(REG_GROW_PERIOD, 64'd0);
        add_word(CMD_STEP, 1'b0, 13'sd10);
        // Growth factor below one: scale may fall to zero with no floor.
        add_reg(REG_GROWTH_FACTOR, 64'd0);
        add_word(CMD_STEP, 1'b0, 13'sd10);
        // Zero backoff: floor at 1.0.
        add_reg(REG_BACKOFF_FACTOR, 64'd0);
        add_word(CMD_STEP, 1'b1, 13'sd10);
        // Backoff above one from the register maximum: saturate at 33 bits.
        add_reg(REG_BACKOFF_FACTOR, 64'hF_FFFF);
        add_reg(REG_INITIAL_SCALE, {31'd0, SCALE_MAX});
        add_word(CMD_REENABLE, 1'b0, 13'sd0);
        add_word(CMD_STEP, 1'b1, 13'sd0);
        // Zero overflow limit: first overflow forces FP32.
        add_reg(REG_OVERFLOW_LIMIT, 64'd0);
        add_word(CMD_REENABLE, 1'b0, 13'sd0);
        add_word(CMD_STEP, 1'b1, 13'sd20);
        // Threshold at both extremes.
        add_reg(REG_THROTTLE_TEMP, 64'h1000);
        add_word(CMD_STEP, 1'b0, 13'sh1000);
        add_reg(REG_THROTTLE_TEMP, 64'h0FFF);
        add_word(CMD_STEP, 1'b0, 13'sh0FFF);
        add_word(CMD_STEP, 1'b0, 13'sh0FFE);
        add_reg(REG_INITIAL_SCALE, 64'd65536);
        add_word(CMD_REENABLE, 1'b0, 13'sd0);
        add_word(CMD_STEP, 1'b1, 13'sd0);

        // Hold reset, then release it once, never again.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; drain before each register write.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain_results();
                write_reg(row.idx, row.value);
            end
            else
            begin
                drive_word(row.cmd, row.ovf, row.temp, row.pin);
            end
        end

        // Random phases, each with its own register settings and overflow rate.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            program_registers(phase);
            no_idle = (phase == 2) || (phase % 4 == 3);
            ovf_pct = $urandom_range(5, 60);
            // Long receiver hold-off while the sender keeps offering words.
            if (phase == 2)
                hold_pending = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Sender pause: wait for every outstanding result mid-phase.
                if (phase == 6 && n == PHASE_WORDS / 2)
                    drain_results();
                c = ($urandom_range(0, 99) < 6) ? CMD_REENABLE : CMD_STEP;
                o = ($urandom_range(0, 99) < ovf_pct);
                drive_word(c, o, pick_temperature(), no_pin);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/dlsc_pkg.sv
hdl/dlsc_if.sv
hdl/dynamic_loss_scale_controller_top.sv
tb/tb_dynamic_loss_scale_controller_top.sv
